// File: hw/rtl/chm_pkg.sv
// Package: sizes, null link, request codes and controller states for the hash map engine.
`timescale 1ns / 1ps
package chm_pkg;
  localparam int NUM_BUCKETS = 256;
  localparam int MAX_ENTRIES = 192;
  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int EW = 8;
  localparam logic [EW-1:0] NIL = 8'hFF;

  typedef enum logic [1:0] {
    REQ_SET   = 2'd0,
    REQ_GET   = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD,
    ST_WALK,
    ST_CHK,
    ST_ALLOC,
    ST_CLR_RD,
    ST_CLR_HEAD,
    ST_CLR_LINK,
    ST_CLR_WB
  } state_t;
endpackage

// File: hw/rtl/chained_hash_map_engine_unit.sv
// Top level: chained hash table engine with bucket-head and entry memories.
`timescale 1ns / 1ps
// Transfer to done: set and get read the bucket head (HEAD), then pass WALK and CHK per chain entry;
// a set that takes its entry from the free list adds ALLOC; an unknown code finishes from idle.
// Clear: sweeps the bucket memory (CLR_RD, CLR_HEAD, CLR_LINK per bucket, CLR_WB per stored entry).
// One request at a time: busy is high from the transfer until the done strobe.
// The chain walk through the registered-read entry memory sets the rate.
// Reset (synchronous, rst): clears the bucket valid bits, free list, pool and count at once.
// The receiver cannot stall: done is a one-cycle strobe.
module chained_hash_map_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        done,
  output logic        hit,
  output logic [31:0] read_value,
  output logic        status,
  output logic [7:0]  entry_count
);
  import chm_pkg::*;

  // Memories: bucket heads with per-bucket valid bits (invalid reads as null)
  logic [EW-1:0] heads [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] head_vld;
  logic [31:0] ekeys [MAX_ENTRIES];
  logic [31:0] evals [MAX_ENTRIES];
  logic [EW-1:0] elinks [MAX_ENTRIES];

  state_t state, state_next;
  logic [1:0]  rq;
  logic [31:0] rkey, rval;
  logic [BW-1:0] bkt;
  logic [EW-1:0] cur;
  logic [7:0] steps;
  logic [EW-1:0] free_head, next_unused;
  logic [7:0] stored_count;

  // registered read data
  logic [EW-1:0] head_q;
  logic head_vq;
  logic [31:0] key_q, val_q;
  logic [EW-1:0] link_q;

  // combinational controls
  logic h_we; logic [BW-1:0] h_wa; logic [EW-1:0] h_wd; logic h_clr;
  logic e_rd; logic [EW-1:0] e_ra;
  logic k_we, v_we, l_we; logic [EW-1:0] e_wa, l_wa, l_wd; logic [31:0] k_wd;
  logic [BW-1:0] h_ra;
  logic fin;
  logic [EW-1:0] head_eff;

  assign head_eff = head_vq ? head_q : NIL;
  assign busy = (state != ST_IDLE);

  function automatic logic vld(input logic [EW-1:0] e);
    return e < EW'(MAX_ENTRIES);
  endfunction

  always_ff @(posedge clk) begin
    if (h_we) heads[h_wa] <= h_wd;
    head_q  <= heads[h_ra];
    head_vq <= head_vld[h_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) head_vld <= '0;
    else if (h_we) head_vld[h_wa] <= ~h_clr;
  end

  always_ff @(posedge clk) begin
    if (k_we) ekeys[e_wa[7:0]] <= k_wd;
    if (v_we) evals[e_wa[7:0]] <= rval;
    if (l_we) elinks[l_wa[7:0]] <= l_wd;
    if (e_rd && vld(e_ra)) begin
      key_q  <= ekeys[e_ra[7:0]];
      val_q  <= evals[e_ra[7:0]];
      link_q <= elinks[e_ra[7:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    h_we = 1'b0; h_wa = bkt; h_wd = NIL; h_clr = 1'b0; h_ra = bkt;
    e_rd = 1'b0; e_ra = cur;
    k_we = 1'b0; v_we = 1'b0; l_we = 1'b0; e_wa = cur; l_wa = cur; l_wd = NIL;
    k_wd = rkey; fin = 1'b0;
    case (state)
      ST_IDLE: begin
        h_ra = key[BW-1:0];
        if (start) begin
          if (req_type == REQ_SET || req_type == REQ_GET) state_next = ST_HEAD;
          else if (req_type == REQ_CLEAR) state_next = ST_CLR_RD;
          else fin = 1'b1;
        end
      end
      ST_HEAD: begin
        // head read back; issue first entry read
        e_rd = 1'b1; e_ra = head_eff;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (!vld(cur) || steps >= 8'(MAX_ENTRIES)) begin
          fin = 1'b1; state_next = ST_IDLE;
          if (rq == REQ_SET) begin
            if (vld(free_head)) begin
              // fetch the link of the free entry before popping it
              e_rd = 1'b1; e_ra = free_head;
              fin = 1'b0; state_next = ST_ALLOC;
            end else if (next_unused < EW'(MAX_ENTRIES)) begin
              e_wa = next_unused;
              k_we = 1'b1; v_we = 1'b1; l_we = 1'b1; l_wa = next_unused;
              l_wd = head_eff; h_we = 1'b1; h_wd = next_unused;
            end
          end
        end else state_next = ST_CHK;
      end
      ST_CHK: begin
        if (key_q == rkey) begin
          fin = 1'b1; state_next = ST_IDLE;
          if (rq == REQ_SET) v_we = 1'b1;
        end else begin
          e_rd = 1'b1; e_ra = link_q;
          state_next = ST_WALK;
        end
      end
      ST_ALLOC: begin
        e_wa = free_head;
        k_we = 1'b1; v_we = 1'b1; l_we = 1'b1; l_wa = free_head;
        l_wd = head_eff; h_we = 1'b1; h_wd = free_head;
        fin = 1'b1; state_next = ST_IDLE;
      end
      ST_CLR_RD: state_next = ST_CLR_HEAD;
      ST_CLR_HEAD: begin
        e_rd = 1'b1; e_ra = head_eff;
        state_next = ST_CLR_LINK;
      end
      ST_CLR_LINK: begin
        if (!vld(cur) || steps >= 8'(MAX_ENTRIES)) begin
          h_we = 1'b1; h_clr = 1'b1;
          if (bkt == BW'(NUM_BUCKETS - 1)) begin
            fin = 1'b1; state_next = ST_IDLE;
          end else state_next = ST_CLR_RD;
        end else state_next = ST_CLR_WB;
      end
      ST_CLR_WB: begin
        l_we = 1'b1; l_wa = cur; l_wd = free_head;
        e_rd = 1'b1; e_ra = link_q;
        state_next = ST_CLR_LINK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= NIL; next_unused <= '0; stored_count <= '0; done <= 1'b0;
    end else begin
      done <= fin;
      case (state)
        ST_IDLE: if (start) begin
          rq <= req_type; rkey <= key; rval <= value;
          bkt <= (req_type == REQ_CLEAR) ? '0 : key[BW-1:0]; steps <= '0;
          hit <= 1'b0; read_value <= '0; status <= 1'b0;
          entry_count <= stored_count;
        end
        ST_HEAD: cur <= head_eff;
        ST_WALK: if (fin && rq == REQ_SET) begin
          if (next_unused < EW'(MAX_ENTRIES)) begin
            next_unused <= next_unused + 8'd1;
            entry_count <= stored_count + 8'(stored_count != 8'hFF);
            stored_count <= stored_count + 8'(stored_count != 8'hFF);
          end else status <= 1'b1;
        end
        ST_CHK: begin
          if (fin) begin
            hit <= 1'b1;
            if (rq == REQ_GET) read_value <= val_q;
          end else begin
            cur <= link_q; steps <= steps + 8'd1;
          end
        end
        ST_ALLOC: begin
          free_head <= link_q;
          entry_count <= stored_count + 8'(stored_count != 8'hFF);
          stored_count <= stored_count + 8'(stored_count != 8'hFF);
        end
        ST_CLR_RD: steps <= '0;
        ST_CLR_HEAD: cur <= head_eff;
        ST_CLR_LINK: if (!vld(cur) || steps >= 8'(MAX_ENTRIES)) begin
          bkt <= bkt + BW'(1);
          if (fin) begin stored_count <= '0; entry_count <= '0; end
        end
        ST_CLR_WB: begin
          free_head <= cur; cur <= link_q; steps <= steps + 8'd1;
        end
        default: ;
      endcase
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    (done && !(start && !busy)) |=> !done)
    else $error("done held without a new transfer");
  a_busy_done: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    stored_count <= 8'(MAX_ENTRIES)) else $error("count beyond pool");
endmodule
